### rtl/sfs_pkg.sv
// sfs_pkg: shared constants, command codes, sequencer states and types for the
// sprite frame sequencer. No dependencies.
`default_nettype none
package sfs_pkg;

  localparam int NUM_SLOTS  = 8;
  localparam int MAX_FRAMES = 16;
  localparam int MAX_STEPS  = 64;

  localparam int SLOT_W  = $clog2(NUM_SLOTS);
  localparam int POS_W   = $clog2(MAX_FRAMES);
  localparam int ADDR_W  = SLOT_W + POS_W;
  localparam int DEPTH   = NUM_SLOTS * MAX_FRAMES;
  localparam int COUNT_W = $clog2(MAX_FRAMES + 1);
  localparam int STEP_W  = $clog2(MAX_STEPS + 1);

  localparam logic [15:0] SPEED_GAIN_RESET = 16'd256;

  typedef enum logic [2:0] {
    CMD_TICK        = 3'd0,
    CMD_PLAY        = 3'd1,
    CMD_STOP        = 3'd2,
    CMD_PAUSE       = 3'd3,
    CMD_RESUME      = 3'd4,
    CMD_WRITE_FRAME = 3'd5,
    CMD_WRITE_ANIM  = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL1,
    ST_MUL2,
    ST_ACC,
    ST_CHECK,
    ST_RESULT
  } state_t;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_SATADD,
    OP_CMPSUB
  } alu_op_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [15:0]       dur;
    logic [63:0]       rect;
  } frame_wr_t;

  typedef struct packed {
    logic [15:0] dur;
    logic [63:0] rect;
  } frame_rd_t;

endpackage
`default_nettype wire

### rtl/sprite_frame_sequencer.sv
// sprite_frame_sequencer: top level; command decode, sequencer, playback state
// and output register. Depends on sfs_pkg, sfs_frame_store, sfs_step_unit.
//
//   channel  | handshake              | beat
//   ---------+------------------------+----------------------------------------
//   in       | in_valid / in_stall    | cmd, anim_index, frame fields, speeds
//   out      | out_valid / out_stall  | rect_valid, rectangle, flags, position
//   cfg      | cfg_wr_en              | cfg_wr_data -> speed_gain
//
// Commands other than tick pass from decode straight to the result state.
// A playing tick advances at most 64 frames: two multiply passes and one
// accumulate pass through the shared unit, then one compare/subtract pass per
// frame read from the frame store.
// Sync reset clears slot defined bits and playback state; tables are unwritten.
// The next beat is accepted while a result waits in the output register.
`default_nettype none
module sprite_frame_sequencer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  cmd,
  input  wire logic [2:0]  anim_index,
  input  wire logic [3:0]  frame_index,
  input  wire logic        option_flag,
  input  wire logic [15:0] delta_time,
  input  wire logic [15:0] frame_duration,
  input  wire logic signed [15:0] rect_left,
  input  wire logic signed [15:0] rect_top,
  input  wire logic signed [15:0] rect_width,
  input  wire logic signed [15:0] rect_height,
  input  wire logic [4:0]  frame_count,
  input  wire logic [15:0] anim_speed,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             rect_valid,
  output logic signed [15:0] out_left,
  output logic signed [15:0] out_top,
  output logic signed [15:0] out_width,
  output logic signed [15:0] out_height,
  output logic             ok,
  output logic             is_playing,
  output logic             is_finished,
  output logic [2:0]       active_slot,
  output logic [3:0]       active_frame,
  output logic             overrun
);

  localparam int SW = sfs_pkg::SLOT_W;
  localparam int PW = sfs_pkg::POS_W;
  localparam int CW = sfs_pkg::COUNT_W;
  localparam int TW = sfs_pkg::STEP_W;

  sfs_pkg::state_t state, state_next;

  logic [15:0] speed_gain;

  // latched beat
  sfs_pkg::cmd_t cmd_q;
  logic [2:0]  anim_q;
  logic [3:0]  fidx_q;
  logic        opt_q;
  logic [15:0] delta_q;
  logic [15:0] dur_q;
  logic [63:0] rect_q;
  logic [4:0]  count_q;
  logic [15:0] speed_q;

  // slot table
  logic [sfs_pkg::NUM_SLOTS-1:0] slot_defined, slot_defined_next;
  logic          slot_loop  [sfs_pkg::NUM_SLOTS];
  logic [CW-1:0] slot_count [sfs_pkg::NUM_SLOTS];
  logic [15:0]   slot_speed [sfs_pkg::NUM_SLOTS];

  // playback state
  logic [SW-1:0] selected_slot, selected_slot_next;
  logic          slot_chosen, slot_chosen_next;
  logic [PW-1:0] frame_position, frame_position_next;
  logic [31:0]   elapsed, elapsed_next;
  logic          playing_flag, playing_flag_next;
  logic          finished_flag, finished_flag_next;

  logic [47:0]   acc, acc_next;
  logic [TW-1:0] steps, steps_next;
  logic [63:0]   res_rect, res_rect_next;
  logic          res_valid, res_valid_next;
  logic          res_ok, res_ok_next;
  logic          res_overrun, res_overrun_next;

  sfs_pkg::alu_op_t alu_op;
  logic [47:0]      alu_a;
  logic [31:0]      alu_b;
  logic [47:0]      alu_y;
  logic             alu_ge;

  sfs_pkg::frame_wr_t fwr;
  sfs_pkg::frame_rd_t frd;

  logic          in_accept;
  logic          out_load;
  logic [SW-1:0] cur_slot;
  logic [SW-1:0] arg_slot;
  logic          arg_slot_ok;
  logic          arg_frame_ok;
  logic [CW-1:0] cur_count;
  logic          tick_active;
  logic [CW:0]   pos_inc;

  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state == sfs_pkg::ST_RESULT) && (!out_valid || !out_stall);

  assign cur_slot     = selected_slot;
  assign arg_slot     = anim_q[SW-1:0];
  assign arg_slot_ok  = 32'(anim_q) < sfs_pkg::NUM_SLOTS;
  assign arg_frame_ok = 32'(fidx_q) < sfs_pkg::MAX_FRAMES;
  assign cur_count    = slot_count[cur_slot];
  assign tick_active  = playing_flag && slot_chosen && slot_defined[cur_slot] &&
                        (cur_count != CW'(0));
  assign pos_inc      = (CW+1)'(frame_position) + (CW+1)'(1);

  sfs_step_unit u_step (
    .op  (alu_op),
    .opa (alu_a),
    .opb (alu_b),
    .y   (alu_y),
    .ge  (alu_ge)
  );

  sfs_frame_store u_store (
    .clk     (clk),
    .wr      (fwr),
    .rd_addr ({selected_slot_next, frame_position_next}),
    .rd      (frd)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sfs_pkg::ST_IDLE:   if (in_accept) state_next = sfs_pkg::ST_DECODE;
      sfs_pkg::ST_DECODE: begin
        if (cmd_q == sfs_pkg::CMD_TICK && tick_active) state_next = sfs_pkg::ST_MUL1;
        else state_next = sfs_pkg::ST_RESULT;
      end
      sfs_pkg::ST_MUL1:   state_next = sfs_pkg::ST_MUL2;
      sfs_pkg::ST_MUL2:   state_next = sfs_pkg::ST_ACC;
      sfs_pkg::ST_ACC:    state_next = sfs_pkg::ST_CHECK;
      sfs_pkg::ST_CHECK: begin
        if (steps == TW'(sfs_pkg::MAX_STEPS) || !(playing_flag && alu_ge)) begin
          state_next = sfs_pkg::ST_RESULT;
        end
      end
      sfs_pkg::ST_RESULT: if (out_load) state_next = sfs_pkg::ST_IDLE;
      default:            state_next = sfs_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_stall = (state != sfs_pkg::ST_IDLE);
    alu_op   = sfs_pkg::OP_CMPSUB;
    alu_a    = {32'd0, elapsed[31:16]};
    alu_b    = {16'd0, frd.dur};

    fwr.en   = 1'b0;
    fwr.addr = {arg_slot, fidx_q[PW-1:0]};
    fwr.dur  = dur_q;
    fwr.rect = rect_q;

    slot_defined_next   = slot_defined;
    selected_slot_next  = selected_slot;
    slot_chosen_next    = slot_chosen;
    frame_position_next = frame_position;
    elapsed_next        = elapsed;
    playing_flag_next   = playing_flag;
    finished_flag_next  = finished_flag;
    acc_next            = acc;
    steps_next          = steps;
    res_rect_next       = res_rect;
    res_valid_next      = res_valid;
    res_ok_next         = res_ok;
    res_overrun_next    = res_overrun;

    case (state)
      sfs_pkg::ST_DECODE: begin
        res_valid_next   = 1'b0;
        res_ok_next      = 1'b1;
        res_overrun_next = 1'b0;
        res_rect_next    = 64'd0;
        steps_next       = TW'(0);
        case (cmd_q)
          sfs_pkg::CMD_TICK: begin
            if (tick_active && ({1'b0, frame_position} >= cur_count)) begin
              frame_position_next = PW'(cur_count - CW'(1));
            end
          end
          sfs_pkg::CMD_PLAY: begin
            if (!arg_slot_ok || !slot_defined[arg_slot]) begin
              res_ok_next = 1'b0;
            end else if (slot_chosen && selected_slot == arg_slot && !opt_q) begin
              if (!playing_flag) begin
                playing_flag_next  = 1'b1;
                finished_flag_next = 1'b0;
              end
            end else begin
              selected_slot_next  = arg_slot;
              slot_chosen_next    = 1'b1;
              frame_position_next = PW'(0);
              elapsed_next        = 32'd0;
              playing_flag_next   = 1'b1;
              finished_flag_next  = 1'b0;
            end
          end
          sfs_pkg::CMD_STOP: begin
            playing_flag_next   = 1'b0;
            frame_position_next = PW'(0);
            elapsed_next        = 32'd0;
            finished_flag_next  = 1'b0;
          end
          sfs_pkg::CMD_PAUSE: playing_flag_next = 1'b0;
          sfs_pkg::CMD_RESUME: begin
            if (!finished_flag) playing_flag_next = 1'b1;
          end
          sfs_pkg::CMD_WRITE_FRAME: fwr.en = arg_slot_ok && arg_frame_ok;
          sfs_pkg::CMD_WRITE_ANIM: begin
            if (arg_slot_ok) slot_defined_next[arg_slot] = 1'b1;
          end
          default: ;
        endcase
      end
      sfs_pkg::ST_MUL1: begin
        alu_op   = sfs_pkg::OP_MUL;
        alu_a    = {32'd0, delta_q};
        alu_b    = {16'd0, speed_gain};
        acc_next = alu_y;
      end
      sfs_pkg::ST_MUL2: begin
        alu_op   = sfs_pkg::OP_MUL;
        alu_a    = {16'd0, acc[31:0]};
        alu_b    = {16'd0, slot_speed[cur_slot]};
        acc_next = alu_y;
      end
      sfs_pkg::ST_ACC: begin
        alu_op       = sfs_pkg::OP_SATADD;
        alu_a        = acc;
        alu_b        = elapsed;
        elapsed_next = alu_y[31:0];
      end
      sfs_pkg::ST_CHECK: begin
        if (steps == TW'(sfs_pkg::MAX_STEPS)) begin
          res_overrun_next = playing_flag && alu_ge;
          res_valid_next   = 1'b1;
          res_rect_next    = frd.rect;
        end else if (playing_flag && alu_ge) begin
          elapsed_next = {alu_y[15:0], elapsed[15:0]};
          steps_next   = steps + TW'(1);
          if (pos_inc >= (CW+1)'(cur_count)) begin
            if (slot_loop[cur_slot]) begin
              frame_position_next = PW'(0);
            end else begin
              frame_position_next = PW'(cur_count - CW'(1));
              playing_flag_next   = 1'b0;
              finished_flag_next  = 1'b1;
            end
          end else begin
            frame_position_next = PW'(pos_inc);
          end
        end else begin
          res_valid_next = 1'b1;
          res_rect_next  = frd.rect;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= sfs_pkg::ST_IDLE;
      speed_gain     <= sfs_pkg::SPEED_GAIN_RESET;
      slot_defined   <= '0;
      selected_slot  <= '0;
      slot_chosen    <= 1'b0;
      frame_position <= '0;
      elapsed        <= 32'd0;
      playing_flag   <= 1'b0;
      finished_flag  <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      if (cfg_wr_en) speed_gain <= cfg_wr_data;
      slot_defined   <= slot_defined_next;
      selected_slot  <= selected_slot_next;
      slot_chosen    <= slot_chosen_next;
      frame_position <= frame_position_next;
      elapsed        <= elapsed_next;
      playing_flag   <= playing_flag_next;
      finished_flag  <= finished_flag_next;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    acc         <= acc_next;
    steps       <= steps_next;
    res_rect    <= res_rect_next;
    res_valid   <= res_valid_next;
    res_ok      <= res_ok_next;
    res_overrun <= res_overrun_next;
    if (in_accept) begin
      cmd_q   <= sfs_pkg::cmd_t'(cmd);
      anim_q  <= anim_index;
      fidx_q  <= frame_index;
      opt_q   <= option_flag;
      delta_q <= delta_time;
      dur_q   <= frame_duration;
      rect_q  <= {rect_height, rect_width, rect_top, rect_left};
      count_q <= frame_count;
      speed_q <= anim_speed;
    end
    if (state == sfs_pkg::ST_DECODE && cmd_q == sfs_pkg::CMD_WRITE_ANIM && arg_slot_ok) begin
      slot_loop[arg_slot]  <= opt_q;
      slot_speed[arg_slot] <= speed_q;
      slot_count[arg_slot] <= (32'(count_q) > sfs_pkg::MAX_FRAMES) ?
                              CW'(sfs_pkg::MAX_FRAMES) : CW'(count_q);
    end
    if (out_load) begin
      rect_valid   <= res_valid;
      out_left     <= res_valid ? res_rect[15:0]  : 16'sd0;
      out_top      <= res_valid ? res_rect[31:16] : 16'sd0;
      out_width    <= res_valid ? res_rect[47:32] : 16'sd0;
      out_height   <= res_valid ? res_rect[63:48] : 16'sd0;
      ok           <= res_ok;
      is_playing   <= playing_flag;
      is_finished  <= finished_flag;
      active_slot  <= 3'(selected_slot);
      active_frame <= 4'(frame_position);
      overrun      <= res_overrun;
    end
  end

endmodule
`default_nettype wire

### rtl/sfs_frame_store.sv
// sfs_frame_store: per-slot frame duration and rectangle memories, one write
// port and one registered read port. Depends on sfs_pkg.
`default_nettype none
module sfs_frame_store (
  input  wire logic                      clk,
  input  wire sfs_pkg::frame_wr_t        wr,
  input  wire logic [sfs_pkg::ADDR_W-1:0] rd_addr,
  output sfs_pkg::frame_rd_t             rd
);

  logic [15:0] dur_mem  [sfs_pkg::DEPTH];
  logic [63:0] rect_mem [sfs_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      dur_mem[wr.addr]  <= wr.dur;
      rect_mem[wr.addr] <= wr.rect;
    end
  end

  always_ff @(posedge clk) begin
    rd.dur  <= dur_mem[rd_addr];
    rd.rect <= rect_mem[rd_addr];
  end

endmodule
`default_nettype wire

### rtl/sfs_step_unit.sv
// sfs_step_unit: shared arithmetic unit of the sequencer: 32x16 multiply,
// 32-bit saturating accumulate, 16-bit compare and subtract. Depends on sfs_pkg.
`default_nettype none
module sfs_step_unit (
  input  wire sfs_pkg::alu_op_t op,
  input  wire logic [47:0]      opa,
  input  wire logic [31:0]      opb,
  output logic      [47:0]      y,
  output logic                  ge
);

  logic [47:0] prod;
  logic [48:0] sum;
  logic [15:0] diff;

  always_comb begin
    prod = 48'(opa[31:0]) * 48'(opb[15:0]);
    sum  = 49'(opa) + 49'(opb);
    diff = opa[15:0] - opb[15:0];
    ge   = opa[15:0] >= opb[15:0];
    case (op)
      sfs_pkg::OP_MUL:    y = prod;
      sfs_pkg::OP_SATADD: y = (sum[48:32] != 17'd0) ? 48'h0000_FFFF_FFFF
                                                    : {16'd0, sum[31:0]};
      sfs_pkg::OP_CMPSUB: y = {32'd0, diff};
      default:            y = 48'd0;
    endcase
  end

endmodule
`default_nettype wire
